// ----- rtl/core/cdo_pkg.sv -----
// ----------------------------------------------------------------------------
// cdo_pkg
// Shared types and constants for the calendar date offset block.
// ----------------------------------------------------------------------------
package cdo_pkg;

  // Beat field widths
  localparam int unsigned DayW    = 5;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned YearW   = 16;
  localparam int unsigned OffsetW = 16;

  // Packed bus widths (data buses rounded up to whole bytes)
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 32;
  localparam int unsigned OutUserW = 2;

  // Gregorian cycle: year mod 400 tracking
  localparam int unsigned YmodW = 9;
  localparam logic [YmodW-1:0] CycleLast = 9'd399;

  localparam logic [MonthW-1:0] MonJan = 4'd1;
  localparam logic [MonthW-1:0] MonFeb = 4'd2;
  localparam logic [MonthW-1:0] MonDec = 4'd12;
  localparam logic [DayW-1:0]   DayFirst = 5'd1;
  localparam logic [DayW-1:0]   DayDecLast = 5'd31;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture the input beat
    logic mod_step;  // one bit of the year mod 400 reduction
    logic check;     // latch the date check result
    logic step;      // move the date by one day
  } cdo_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic mod_last;  // last bit of the reduction is being done
    logic date_ok;   // start date is a valid calendar date
    logic mag_zero;  // no days left to step
  } cdo_sts_t;

  // Leap year from year mod 400
  function automatic logic leap_of(input logic [YmodW-1:0] ymod);
    leap_of = (ymod[1:0] == 2'b00) && (ymod != 9'd100) && (ymod != 9'd200) &&
              (ymod != 9'd300);
  endfunction

  // Month length; zero for a month outside 1..12
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [DayW-1:0] n;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
      MonFeb:                                     n = leap ? 5'd29 : 5'd28;
      default:                                    n = 5'd0;
    endcase
    month_len = n;
  endfunction

endpackage

// ----- rtl/core/cdo_ctrl.sv -----
// ----------------------------------------------------------------------------
// cdo_ctrl
// Sequencer: accept a beat, reduce the year, check the date, step days,
// hold the result until it is taken.
// ----------------------------------------------------------------------------
module cdo_ctrl import cdo_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  cdo_sts_t sts_i,
  output cdo_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MOD   = 5'b00010,
    S_CHECK = 5'b00100,
    S_STEP  = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MOD;
        end
      end
      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_last) state_d = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        if (sts_i.date_ok) state_d = S_STEP;
        else               state_d = S_DONE;
      end
      S_STEP: begin
        if (sts_i.mag_zero) state_d = S_DONE;
        else                cmd_o.step = 1'b1;
      end
      S_DONE: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_DONE);

endmodule

// ----- rtl/core/cdo_datapath.sv -----
// ----------------------------------------------------------------------------
// cdo_datapath
// Date registers, year mod 400 reducer, date check and one-day stepper.
// ----------------------------------------------------------------------------
module cdo_datapath import cdo_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 16,
  parameter int unsigned YEAR_BITS   = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cdo_cmd_t           cmd_i,
  output cdo_sts_t           sts_o,
  input  logic [DayW-1:0]    day_in_i,
  input  logic [MonthW-1:0]  month_in_i,
  input  logic [YearW-1:0]   year_in_i,
  input  logic [OffsetW-1:0] day_offset_i,
  output logic [DayW-1:0]    day_out_o,
  output logic [MonthW-1:0]  month_out_o,
  output logic [YearW-1:0]   year_out_o,
  output logic               input_valid_o,
  output logic               range_error_o
);

  localparam int unsigned CntW = $clog2(YEAR_BITS);
  localparam logic [YEAR_BITS-1:0] YearMax = '1;
  localparam logic [YEAR_BITS-1:0] YearMin = YEAR_BITS'(1);

  logic [DayW-1:0]        day_q;
  logic [MonthW-1:0]      month_q;
  logic [YEAR_BITS-1:0]   year_q;
  logic [YmodW-1:0]       ymod_q;
  logic [CntW-1:0]        bcnt_q;
  logic [OFFSET_BITS-1:0] mag_q;
  logic                   back_q;
  logic                   valid_q;
  logic                   rerr_q;

  logic [OFFSET_BITS-1:0] raw;
  logic [YmodW:0]         ymod_sh;
  logic [YmodW-1:0]       ymod_red;
  logic                   leap;
  logic [DayW-1:0]        len_cur;
  logic [DayW-1:0]        len_prev;
  logic                   at_bound;

  // Offset taken in OFFSET_BITS, sign from its top bit
  assign raw = OFFSET_BITS'(day_offset_i);

  // One bit of year mod 400, MSB first
  assign ymod_sh  = {ymod_q, year_q[bcnt_q]};
  assign ymod_red = (ymod_sh >= 10'd400) ? YmodW'(ymod_sh - 10'd400) : YmodW'(ymod_sh);

  assign leap     = leap_of(ymod_q);
  assign len_cur  = month_len(month_q, leap);
  assign len_prev = month_len(month_q - MonthW'(1), leap);

  // First or last representable date in the stepping direction
  assign at_bound = back_q ?
      (year_q == YearMin && month_q == MonJan && day_q == DayFirst) :
      (year_q == YearMax && month_q == MonDec && day_q == DayDecLast);

  assign sts_o.mod_last = (bcnt_q == '0);
  assign sts_o.date_ok  = (year_q != '0) && (day_q != '0) && (day_q <= len_cur);
  assign sts_o.mag_zero = (mag_q == '0);

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      day_q   <= day_in_i;
      month_q <= month_in_i;
      year_q  <= YEAR_BITS'(year_in_i);
      ymod_q  <= '0;
      bcnt_q  <= CntW'(YEAR_BITS - 1);
      back_q  <= raw[OFFSET_BITS-1];
      mag_q   <= raw[OFFSET_BITS-1] ? (~raw + OFFSET_BITS'(1)) : raw;
    end else if (cmd_i.mod_step) begin
      ymod_q <= ymod_red;
      bcnt_q <= bcnt_q - CntW'(1);
    end else if (cmd_i.step) begin
      if (at_bound) begin
        mag_q <= '0;
      end else begin
        mag_q <= mag_q - OFFSET_BITS'(1);
        if (!back_q) begin
          // forward one day
          if (day_q == len_cur) begin
            day_q <= DayFirst;
            if (month_q == MonDec) begin
              month_q <= MonJan;
              year_q  <= year_q + YEAR_BITS'(1);
              ymod_q  <= (ymod_q == CycleLast) ? '0 : ymod_q + YmodW'(1);
            end else begin
              month_q <= month_q + MonthW'(1);
            end
          end else begin
            day_q <= day_q + DayW'(1);
          end
        end else begin
          // back one day
          if (day_q == DayFirst) begin
            if (month_q == MonJan) begin
              month_q <= MonDec;
              day_q   <= DayDecLast;
              year_q  <= year_q - YEAR_BITS'(1);
              ymod_q  <= (ymod_q == '0) ? CycleLast : ymod_q - YmodW'(1);
            end else begin
              month_q <= month_q - MonthW'(1);
              day_q   <= len_prev;
            end
          end else begin
            day_q <= day_q - DayW'(1);
          end
        end
      end
    end
  end

  // Result flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rerr_q  <= 1'b0;
    end else if (cmd_i.load) begin
      valid_q <= 1'b0;
      rerr_q  <= 1'b0;
    end else if (cmd_i.check) begin
      valid_q <= sts_o.date_ok;
    end else if (cmd_i.step && at_bound) begin
      rerr_q <= 1'b1;
    end
  end

  assign day_out_o     = day_q;
  assign month_out_o   = month_q;
  assign year_out_o    = YearW'(year_q);
  assign input_valid_o = valid_q;
  assign range_error_o = rerr_q;

  // Checks
  a_step_needs_days: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (mag_q != '0))
    else $error("day step issued with no days left");

  a_ymod_in_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (ymod_q <= CycleLast))
    else $error("year mod 400 out of range");

  a_step_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && !at_bound) |=> (mag_q == $past(mag_q) - OFFSET_BITS'(1)))
    else $error("day counter did not count down");

  a_rerr_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rerr_q |-> valid_q)
    else $error("range error on an invalid start date");

endmodule

// ----- rtl/core/calendar_date_offset_top.sv -----
// Flow: from input beat to result, year mod 400 is reduced one bit per cycle,
//   the date is checked, then one day is stepped per cycle; an invalid date
//   skips stepping, a saturating run stops at the bound.
// Throughput: one item at a time; the next beat is taken after the result beat.
// Reset: asynchronous, active low; returns to idle with no result pending.
// ----------------------------------------------------------------------------
// calendar_date_offset_top
// Gregorian date plus a signed number of days, with date check and
// saturation at the first and last representable dates.
// ----------------------------------------------------------------------------
module calendar_date_offset_top import cdo_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 16,
  parameter int unsigned YEAR_BITS   = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // day_in[4:0], month_in[8:5], year_in[24:9], day_offset[40:25], zero pad
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // day_out[4:0], month_out[8:5], year_out[24:9], zero pad
  output logic [OutDataW-1:0] m_axis_tdata,
  // input_valid[0], range_error[1]
  output logic [OutUserW-1:0] m_axis_tuser
);

  cdo_cmd_t cmd;
  cdo_sts_t sts;

  logic [DayW-1:0]   day_out;
  logic [MonthW-1:0] month_out;
  logic [YearW-1:0]  year_out;
  logic              input_valid;
  logic              range_error;

  cdo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cdo_datapath #(
    .OFFSET_BITS (OFFSET_BITS),
    .YEAR_BITS   (YEAR_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .day_in_i      (s_axis_tdata[4:0]),
    .month_in_i    (s_axis_tdata[8:5]),
    .year_in_i     (s_axis_tdata[24:9]),
    .day_offset_i  (s_axis_tdata[40:25]),
    .day_out_o     (day_out),
    .month_out_o   (month_out),
    .year_out_o    (year_out),
    .input_valid_o (input_valid),
    .range_error_o (range_error)
  );

  // Result beat packing
  assign m_axis_tdata = {7'd0, year_out, month_out, day_out};
  assign m_axis_tuser = {range_error, input_valid};

endmodule
